@@ rtl/ccra_pkg.sv @@
package ccra_pkg;

    // Fixed field widths of the request, result and capacity register.
    localparam int LEN_W  = 12;
    localparam int OFF_W  = 12;
    localparam int CAP_W  = 12;
    localparam int MODE_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 12'd4095;
    localparam int DEF_RING_BYTES = 4096;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISCARD = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEND
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

@@ rtl/ccra_if.sv @@
interface ccra_req_if;
    import ccra_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output mode, output length, input ready);
    modport sink   (input valid, input mode, input length, output ready);
endinterface

interface ccra_rsp_if;
    import ccra_pkg::*;
    logic             valid;
    logic             ready;
    logic             ok;
    logic [OFF_W-1:0] offset;

    modport source (output valid, output ok, output offset, input ready);
    modport sink   (input valid, input ok, input offset, output ready);
endinterface

@@ rtl/ccra_ctrl.sv @@
module ccra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ccra_pkg::t_cmd o_cmd
);
    import ccra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.execute = 1'b1;
                n_state       = ST_SEND;
            end
            ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ccra_datapath.sv @@
module ccra_datapath #(
    parameter int RING_BYTES = ccra_pkg::DEF_RING_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ccra_pkg::CAP_W-1:0]  i_cfg_wr_data,
    input  logic [ccra_pkg::MODE_W-1:0] i_mode,
    input  logic [ccra_pkg::LEN_W-1:0]  i_length,
    input  ccra_pkg::t_cmd              i_cmd,
    output logic                        o_ok,
    output logic [ccra_pkg::OFF_W-1:0]  o_offset
);
    import ccra_pkg::*;

    // Marks must hold the full ring span, which reaches RING_BYTES.
    localparam int MW = $clog2(RING_BYTES + 1);
    localparam int CW = (MW > LEN_W) ? MW : LEN_W;
    localparam logic [CW-1:0] CAP_LIM = CW'(RING_BYTES - 1);

    function automatic logic [CW-1:0] span_of(input logic [CAP_W-1:0] cap);
        logic [CW-1:0] c;
        c = CW'(cap);
        if (c > CAP_LIM) begin
            c = CAP_LIM;
        end
        return c + CW'(1);
    endfunction

    logic [MW-1:0]     r_wm, r_rm, r_em;
    logic [CAP_W-1:0]  r_cap;
    logic [MODE_W-1:0] r_mode;
    logic [LEN_W-1:0]  r_len;
    logic              r_ok;
    logic [OFF_W-1:0]  r_off;

    logic [CW-1:0] w, r, e, l, span, r1, e1, avail, rnext, off;
    logic [CW-1:0] n_w, n_r, n_e;
    logic          n_ok;

    always_comb begin
        w     = CW'(r_wm);
        r     = CW'(r_rm);
        e     = CW'(r_em);
        l     = CW'(r_len);
        span  = span_of(r_cap);
        n_w   = w;
        n_r   = r;
        n_e   = e;
        n_ok  = 1'b0;
        off   = '0;
        r1    = r;
        e1    = e;
        avail = '0;
        rnext = '0;
        case (r_mode)
            MODE_PUSH: begin
                if (w >= r) begin
                    if ((e - w) < l) begin
                        if (r > l) begin
                            n_ok = 1'b1;
                            n_e  = w;
                            off  = '0;
                            n_w  = l;
                        end
                    end else begin
                        n_ok = 1'b1;
                        off  = w;
                        n_w  = w + l;
                    end
                end else if ((r - w) > l) begin
                    n_ok = 1'b1;
                    off  = w;
                    n_w  = w + l;
                end
            end
            MODE_POP, MODE_DISCARD: begin
                // A read mark parked on the end mark wraps first, even if refused.
                if ((w < r) && (r == e)) begin
                    r1 = '0;
                    e1 = span;
                end
                n_r   = r1;
                n_e   = e1;
                avail = (w > r1) ? (w - r1) : (e1 - r1);
                rnext = r1 + l;
                if ((w != r1) && (l <= avail)) begin
                    n_ok = 1'b1;
                    off  = r1;
                    n_r  = rnext;
                    if (rnext == e1) begin
                        if (w == e1) begin
                            n_w = '0;
                        end
                        n_r = '0;
                        n_e = span;
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_wm  <= '0;
            r_rm  <= '0;
            r_em  <= MW'(span_of(CAP_RESET));
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
            r_wm  <= '0;
            r_rm  <= '0;
            r_em  <= MW'(span_of(i_cfg_wr_data));
        end else if (i_cmd.execute) begin
            r_wm <= n_w[MW-1:0];
            r_rm <= n_r[MW-1:0];
            r_em <= n_e[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_len  <= i_length;
        end
        if (i_cmd.execute) begin
            r_ok  <= n_ok;
            r_off <= off[OFF_W-1:0];
        end
    end

    assign o_ok     = r_ok;
    assign o_offset = r_off;

endmodule

@@ rtl/contiguous_chunk_ring_allocator_unit.sv @@
// Channel   Direction  Beat contents
// i_req     in         mode (push, pop, discard), length in bytes
// o_rsp     out        ok flag, start offset of the chunk in ring memory
// i_cfg_*   in         capacity write (usable ring bytes minus one), no read-back
//
// Each request passes through capture of the beat, the mark update in
// the datapath, and presentation of the result to the output channel.
// The result stays on o_rsp until it is taken; a stalled sink holds off
// the next request, since the marks are updated one request at a time.
// Reset (synchronous, active low) sets capacity to 4095 and resets the
// marks; a capacity write re-initializes the marks in the same way.
module contiguous_chunk_ring_allocator_unit #(
    parameter int RING_BYTES = ccra_pkg::DEF_RING_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ccra_pkg::CAP_W-1:0] i_cfg_wr_data,
    ccra_req_if.sink                   i_req,
    ccra_rsp_if.source                 o_rsp
);
    import ccra_pkg::*;

    t_cmd cmd;

    // The controller sequences capture, update and result delivery.
    ccra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // The datapath owns the capacity register, the three marks and the
    // result register that feeds the output channel directly.
    ccra_datapath #(
        .RING_BYTES (RING_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mode        (i_req.mode),
        .i_length      (i_req.length),
        .i_cmd         (cmd),
        .o_ok          (o_rsp.ok),
        .o_offset      (o_rsp.offset)
    );

    // A result is never pending while a new request can be taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rsp.valid && i_req.ready))
        else $error("request ready while a result is pending");

    // After a request beat, no further request is taken in the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while one is in flight");

    // A refused request reports offset zero.
    a_refused_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ok) |-> (o_rsp.offset == '0))
        else $error("refused request with nonzero offset");

    // A result beat is followed by readiness for the next request.
    a_return_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> i_req.ready)
        else $error("controller did not return to idle after a result");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the contiguous chunk ring allocator.
// A short table of hand-picked requests runs first at the reset capacity.
// Several capacity settings follow, each with a run of random push, pop and
// discard beats. Every response beat is checked against a model of the
// read, write and end marks kept here.
module tb_top;
    import ccra_pkg::*;

    localparam int STUCK_LIMIT   = 1000;
    localparam int PHASES        = 10;
    localparam int BEATS_PER_SET = 105;
    localparam int DIRECTED_ROWS = 21;
    // A negative capacity is not possible, so a negative value in the
    // phase table asks for a random capacity instead.
    localparam int CAP_RANDOM    = -1;

    // One response beat as the block should present it.
    typedef struct packed {
        logic             ok;
        logic [OFF_W-1:0] offset;
    } t_chunk_result;

    // One row of the directed table. When pinned is set, the response is
    // taken from the row itself rather than from the mark model.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  len;
        logic              pinned;
        logic              ok;
        logic [OFF_W-1:0]  offset;
    } t_chunk_probe;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CAP_W-1:0] i_cfg_wr_data;

    ccra_req_if req_if ();
    ccra_rsp_if rsp_if ();

    contiguous_chunk_ring_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    // Mirror of the allocator state. The marks are kept as plain integers,
    // since the write mark may rest one past the last usable byte.
    logic [CAP_W-1:0] cap_reg;
    int unsigned wr_mark;
    int unsigned rd_mark;
    int unsigned end_mark;

    t_chunk_result pending_chunks[$];

    bit idle_on;
    int unsigned rsp_stall_left;
    int unsigned stuck_cycles;
    int error_count;
    int requests_sent;
    int granted_count;
    int refused_count;
    int settings_used;

    // The directed table runs at the reset capacity of 4095, a ring of
    // 4096 bytes. Pinned rows are the ones whose answer is obvious: refusals
    // and the requests that touch the ends of the ring.
    t_chunk_probe directed_probes [DIRECTED_ROWS] = '{
        // Pop and discard on an empty ring are refused, even for length zero.
        '{MODE_POP,     12'd0,    1'b1, 1'b0, 12'd0},
        '{MODE_DISCARD, 12'd0,    1'b1, 1'b0, 12'd0},
        // An empty push, then fill the ring to its very last byte.
        '{MODE_PUSH,    12'd0,    1'b1, 1'b1, 12'd0},
        '{MODE_PUSH,    12'd4095, 1'b1, 1'b1, 12'd0},
        '{MODE_PUSH,    12'd2,    1'b1, 1'b0, 12'd0},
        '{MODE_PUSH,    12'd1,    1'b1, 1'b1, 12'd4095},
        // The write mark now sits one past the end; a zero push reports it
        // truncated to twelve bits.
        '{MODE_PUSH,    12'd0,    1'b1, 1'b1, 12'd0},
        '{MODE_POP,     12'd4095, 1'b1, 1'b1, 12'd0},
        '{MODE_DISCARD, 12'd2,    1'b1, 1'b0, 12'd0},
        // Reading the last byte wraps both marks back to zero.
        '{MODE_DISCARD, 12'd1,    1'b1, 1'b1, 12'd4095},
        '{MODE_POP,     12'd0,    1'b1, 1'b0, 12'd0},
        // Leave the ring empty part way along, then push a chunk that has
        // to wrap to offset zero. The read mark then sits on the end mark.
        '{MODE_PUSH,    12'd3000, 1'b0, 1'b0, 12'd0},
        '{MODE_POP,     12'd3000, 1'b0, 1'b0, 12'd0},
        '{MODE_PUSH,    12'd1200, 1'b0, 1'b0, 12'd0},
        // This pop moves the read mark to zero first, then is refused for
        // being longer than what was written.
        '{MODE_POP,     12'd2000, 1'b1, 1'b0, 12'd0},
        '{MODE_POP,     12'd1200, 1'b0, 1'b0, 12'd0},
        '{MODE_PUSH,    12'd4095, 1'b1, 1'b0, 12'd0},
        '{MODE_DISCARD, 12'd0,    1'b1, 1'b0, 12'd0},
        // A zero-length pop on a ring holding data is granted.
        '{MODE_PUSH,    12'd100,  1'b0, 1'b0, 12'd0},
        '{MODE_POP,     12'd0,    1'b0, 1'b0, 12'd0},
        '{MODE_DISCARD, 12'd100,  1'b0, 1'b0, 12'd0}
    };

    int phase_caps [PHASES] = '{4095, 1, 0, 13, 255, 2048, CAP_RANDOM, CAP_RANDOM,
                                4094, 4095};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_span();
        int unsigned usable;
        usable = cap_reg;
        if (usable > DEF_RING_BYTES - 1) begin
            usable = DEF_RING_BYTES - 1;
        end
        return usable + 1;
    endfunction

    function automatic void clear_marks();
        wr_mark  = 0;
        rd_mark  = 0;
        end_mark = ring_span();
    endfunction

    // Bytes a pop could take right now, counting the read wrap that the
    // next pop would make first.
    function automatic int unsigned bytes_readable();
        if (wr_mark < rd_mark && rd_mark == end_mark) begin
            return wr_mark;
        end
        if (wr_mark > rd_mark) begin
            return wr_mark - rd_mark;
        end
        if (wr_mark < rd_mark) begin
            return end_mark - rd_mark;
        end
        return 0;
    endfunction

    // Applies one request to the mirrored marks and returns the response
    // the block must give for it.
    function automatic t_chunk_result allocate_chunk(input logic [MODE_W-1:0] mode,
                                                     input logic [LEN_W-1:0] len);
        t_chunk_result rsp;
        int unsigned n;
        int unsigned avail;
        int unsigned start;
        n = len;
        start = 0;
        rsp.ok = 1'b0;
        case (mode)
            MODE_PUSH: begin
                if (wr_mark >= rd_mark) begin
                    if (end_mark - wr_mark < n) begin
                        // No room at the top: wrap to zero if the bytes below
                        // the read mark can hold the chunk.
                        if (rd_mark > n) begin
                            end_mark = wr_mark;
                            wr_mark  = 0;
                            rsp.ok   = 1'b1;
                        end
                    end else begin
                        rsp.ok = 1'b1;
                    end
                end else begin
                    rsp.ok = (rd_mark - wr_mark > n);
                end
                if (rsp.ok) begin
                    start   = wr_mark;
                    wr_mark = wr_mark + n;
                end
            end
            MODE_POP, MODE_DISCARD: begin
                if (wr_mark < rd_mark && rd_mark == end_mark) begin
                    rd_mark  = 0;
                    end_mark = ring_span();
                end
                if (wr_mark != rd_mark) begin
                    avail = (wr_mark > rd_mark) ? wr_mark - rd_mark : end_mark - rd_mark;
                    if (n <= avail) begin
                        rsp.ok  = 1'b1;
                        start   = rd_mark;
                        rd_mark = rd_mark + n;
                        if (rd_mark == end_mark) begin
                            if (wr_mark == end_mark) begin
                                wr_mark = 0;
                            end
                            rd_mark  = 0;
                            end_mark = ring_span();
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.offset = start[OFF_W-1:0];
        return rsp;
    endfunction

    // Random lengths mostly stay within a quarter of the ring span for pushes
    // and within the readable bytes for pops, so the marks travel all the way
    // round. Some are fully random, some pops overshoot to provoke refusals.
    function automatic logic [LEN_W-1:0] pick_length(input logic [MODE_W-1:0] mode);
        int unsigned roll;
        int unsigned avail;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return LEN_W'($urandom_range(0, 4095));
        end
        if (mode == MODE_PUSH) begin
            if (roll == 1) begin
                return LEN_W'($urandom_range(0, ring_span()));
            end
            return LEN_W'($urandom_range(0, ring_span() / 4 + 1));
        end
        avail = bytes_readable();
        if (roll == 1) begin
            return LEN_W'(avail + 1);
        end
        return LEN_W'($urandom_range(0, avail));
    endfunction

    // Presents one request beat and holds it until the block takes it.
    // The expected response is queued at the accepting edge. With idling on,
    // a random idle burst may follow; else valid stays high into the next beat.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [LEN_W-1:0] len,
                                input logic pinned,
                                input t_chunk_result pinned_rsp);
        t_chunk_result predicted;
        req_if.valid  <= 1'b1;
        req_if.mode   <= mode;
        req_if.length <= len;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = allocate_chunk(mode, len);
        pending_chunks.push_back(pinned ? pinned_rsp : predicted);
        requests_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every queued response has come back,
    // then lets the block settle before returning.
    task automatic wait_until_drained();
        req_if.valid <= 1'b0;
        while (pending_chunks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // A capacity write also re-initializes the marks, so the mirror does
    // the same at the writing edge.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_reg = value;
        clear_marks();
        settings_used++;
    endtask

    // Response sink: ready drops in random stall bursts while idling is
    // enabled, and stays high otherwise.
    always @(posedge i_clk) begin
        if (rsp_stall_left != 0) begin
            rsp_stall_left = rsp_stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall_left = $urandom_range(1, 10);
        end
        rsp_if.ready <= (rsp_stall_left == 0);
    end

    // Response checker and watchdog. Values are read at the clock edge,
    // before any of this edge's updates land, so both sides of each
    // handshake are seen as they were during the cycle just ending.
    always @(posedge i_clk) begin
        t_chunk_result want;
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles = stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", STUCK_LIMIT);
                $display("Mismatches found");
                $finish;
            end else if (rsp_if.valid && rsp_if.ready) begin
                if (pending_chunks.size() == 0) begin
                    $error("response beat arrived with nothing outstanding");
                    error_count++;
                end else begin
                    want = pending_chunks.pop_front();
                    if (rsp_if.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
                        error_count++;
                    end
                    if (rsp_if.offset !== want.offset) begin
                        $error("offset: expected %0d, got %0d", want.offset, rsp_if.offset);
                        error_count++;
                    end
                    if (rsp_if.ok === 1'b1) begin
                        granted_count++;
                    end else begin
                        refused_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic [MODE_W-1:0] mode;
        logic [CAP_W-1:0] cap_value;
        t_chunk_result pinned_rsp;
        int unsigned roll;

        req_if.valid    = 1'b0;
        req_if.mode     = MODE_PUSH;
        req_if.length   = '0;
        rsp_if.ready    = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_rst_n         = 1'b0;
        idle_on         = 1'b1;
        rsp_stall_left  = 0;
        stuck_cycles    = 0;
        error_count     = 0;
        requests_sent   = 0;
        granted_count   = 0;
        refused_count   = 0;
        settings_used   = 1;
        cap_reg         = CAP_RESET;
        clear_marks();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset capacity.
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            pinned_rsp.ok     = directed_probes[row].ok;
            pinned_rsp.offset = directed_probes[row].offset;
            send_request(directed_probes[row].mode, directed_probes[row].len,
                         directed_probes[row].pinned, pinned_rsp);
        end

        // Random phases, one per capacity setting. Capacity is changed only
        // once the block has returned every response. Some phases run
        // without idling, and the last two have none at all.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_until_drained();
            if (phase_caps[phase] == CAP_RANDOM) begin
                cap_value = CAP_W'($urandom_range(1, 4095));
            end else begin
                cap_value = CAP_W'(phase_caps[phase]);
            end
            idle_on = (phase % 4 != 2) && (phase < PHASES - 2);
            write_capacity(cap_value);
            for (int beat = 0; beat < BEATS_PER_SET; beat++) begin
                // Midway through one phase the sender holds off until all
                // outstanding responses are back, then resumes.
                if (phase == 4 && beat == BEATS_PER_SET / 2) begin
                    wait_until_drained();
                end
                roll = $urandom_range(0, 9);
                if (roll < 5) begin
                    mode = MODE_PUSH;
                end else if (roll < 8) begin
                    mode = MODE_POP;
                end else begin
                    mode = MODE_DISCARD;
                end
                pinned_rsp = '0;
                send_request(mode, pick_length(mode), 1'b0, pinned_rsp);
            end
        end

        wait_until_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d request beats (%0d directed) across %0d capacity settings.",
                 requests_sent, DIRECTED_ROWS, settings_used);
        $display("The block granted %0d and refused %0d of them.",
                 granted_count, refused_count);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ contiguous_chunk_ring_allocator_unit.f @@
rtl/ccra_pkg.sv
rtl/ccra_if.sv
rtl/ccra_ctrl.sv
rtl/ccra_datapath.sv
rtl/contiguous_chunk_ring_allocator_unit.sv
tb/tb_top.sv
